/* src/mtp_pkg.sv */
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared types and constants for the metadata table parser.
// ----------------------------------------------------------------------------
package mtp_pkg;

  localparam int unsigned FOOTER_BYTES     = 16;
  localparam int unsigned MAX_FIELD_LENGTH = 233;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam logic [7:0] SIG_BYTE0 = 8'h4D;
  localparam logic [7:0] SIG_BYTE1 = 8'h44;

  localparam logic [1:0] KIND_IGNORED = 2'd0;
  localparam logic [1:0] KIND_FRAMING = 2'd1;
  localparam logic [1:0] KIND_KEY     = 2'd2;
  localparam logic [1:0] KIND_VALUE   = 2'd3;

  localparam logic [2:0] ST_PARSING = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_NOTABLE = 3'd2;
  localparam logic [2:0] ST_KEYLONG = 3'd3;
  localparam logic [2:0] ST_KEYOVER = 3'd4;
  localparam logic [2:0] ST_VALLONG = 3'd5;
  localparam logic [2:0] ST_VALOVER = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [1:0] byte_kind;
    logic [7:0] entry_number;
    logic       key_done;
    logic       value_done;
    logic [2:0] parse_status;
  } out_word_t;

  typedef struct packed {
    logic is_sig0;
    logic is_sig1;
    logic is_zero;
    logic too_long;
  } byte_class_t;

  typedef struct packed {
    in_word_t    word;
    byte_class_t cls;
  } queue_entry_t;

endpackage

/* src/mtp_front.sv */
// ----------------------------------------------------------------------------
// mtp_front
// Accepts input words and tags each byte with its signature and length class.
// ----------------------------------------------------------------------------
module mtp_front (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mtp_pkg::in_word_t     in_data_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output mtp_pkg::queue_entry_t q_entry_o
);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_entry_o.word         = in_data_i;
    q_entry_o.cls.is_sig0  = (in_data_i.data_byte == mtp_pkg::SIG_BYTE0);
    q_entry_o.cls.is_sig1  = (in_data_i.data_byte == mtp_pkg::SIG_BYTE1);
    q_entry_o.cls.is_zero  = (in_data_i.data_byte == 8'd0);
    q_entry_o.cls.too_long = (in_data_i.data_byte > 8'(mtp_pkg::MAX_FIELD_LENGTH));
  end

endmodule

/* src/mtp_queue.sv */
// ----------------------------------------------------------------------------
// mtp_queue
// Two-entry queue between the classifying front and the parsing back.
// ----------------------------------------------------------------------------
module mtp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mtp_pkg::queue_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output mtp_pkg::queue_entry_t entry_o
);

  localparam int unsigned PtrW = $clog2(mtp_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(mtp_pkg::QUEUE_DEPTH + 1);

  mtp_pkg::queue_entry_t mem_q [mtp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(mtp_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(mtp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(mtp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* src/mtp_back.sv */
// ----------------------------------------------------------------------------
// mtp_back
// Table parser state machine with the blob length register and output register.
// ----------------------------------------------------------------------------
module mtp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic                  q_empty_i,
  input  mtp_pkg::queue_entry_t q_entry_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mtp_pkg::out_word_t    out_data_o
);

  typedef enum logic [2:0] {
    PH_SIG0,
    PH_SIG1,
    PH_COUNT,
    PH_KEYLEN,
    PH_KEY,
    PH_VALLEN,
    PH_VALUE,
    PH_HALT
  } phase_e;

  phase_e             phase_q, phase_d, phase_w;
  logic [31:0]        blen_q;
  logic [31:0]        pos_q, pos_d, pos_w;
  logic [7:0]         keys_q, keys_d, keys_w;
  logic [7:0]         left_q, left_d, left_w;
  logic [7:0]         entry_q, entry_d, entry_w;
  logic [2:0]         status_q, status_d, status_w;
  logic               out_valid_q;
  mtp_pkg::out_word_t out_q, out_d;

  logic [7:0]  b;
  logic [7:0]  left_dec;
  logic [7:0]  keys_dec;
  logic [33:0] end_sum;
  logic        overrun;
  logic        short_blob;

  assign q_pop_o     = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign b = q_entry_i.word.data_byte;

  // restart view of the state
  always_comb begin
    if (q_entry_i.word.first_byte) begin
      phase_w  = PH_SIG0;
      pos_w    = '0;
      keys_w   = '0;
      left_w   = '0;
      entry_w  = '0;
      status_w = mtp_pkg::ST_PARSING;
    end else begin
      phase_w  = phase_q;
      pos_w    = pos_q;
      keys_w   = keys_q;
      left_w   = left_q;
      entry_w  = entry_q;
      status_w = status_q;
    end
  end

  assign end_sum    = {2'b00, pos_w} + {26'd0, b} + 34'(mtp_pkg::FOOTER_BYTES + 1);
  assign overrun    = end_sum > {2'b00, blen_q};
  assign short_blob = blen_q <= 32'(mtp_pkg::FOOTER_BYTES);
  assign left_dec   = left_w - 8'd1;
  assign keys_dec   = keys_w - 8'd1;

  always_comb begin
    phase_d  = phase_w;
    pos_d    = pos_w;
    keys_d   = keys_w;
    left_d   = left_w;
    entry_d  = entry_w;
    status_d = status_w;
    out_d.byte_out     = b;
    out_d.byte_kind    = mtp_pkg::KIND_IGNORED;
    out_d.entry_number = '0;
    out_d.key_done     = 1'b0;
    out_d.value_done   = 1'b0;

    case (phase_w)
      PH_SIG0: begin
        if (short_blob || !q_entry_i.cls.is_sig0) begin
          status_d = mtp_pkg::ST_NOTABLE;
          phase_d  = PH_HALT;
        end else begin
          out_d.byte_kind = mtp_pkg::KIND_FRAMING;
          phase_d         = PH_SIG1;
        end
      end
      PH_SIG1: begin
        if (!q_entry_i.cls.is_sig1) begin
          status_d = mtp_pkg::ST_NOTABLE;
          phase_d  = PH_HALT;
        end else begin
          out_d.byte_kind = mtp_pkg::KIND_FRAMING;
          phase_d         = PH_COUNT;
        end
      end
      PH_COUNT: begin
        out_d.byte_kind = mtp_pkg::KIND_FRAMING;
        keys_d          = b;
        entry_d         = '0;
        if (q_entry_i.cls.is_zero) begin
          status_d = mtp_pkg::ST_DONE;
          phase_d  = PH_HALT;
        end else begin
          phase_d = PH_KEYLEN;
        end
      end
      PH_KEYLEN: begin
        out_d.byte_kind    = mtp_pkg::KIND_FRAMING;
        out_d.entry_number = entry_w;
        if (q_entry_i.cls.too_long) begin
          status_d = mtp_pkg::ST_KEYLONG;
          phase_d  = PH_HALT;
        end else if (overrun) begin
          status_d = mtp_pkg::ST_KEYOVER;
          phase_d  = PH_HALT;
        end else begin
          left_d = b;
          if (q_entry_i.cls.is_zero) begin
            out_d.key_done = 1'b1;
            phase_d        = PH_VALLEN;
          end else begin
            phase_d = PH_KEY;
          end
        end
      end
      PH_KEY: begin
        out_d.byte_kind    = mtp_pkg::KIND_KEY;
        out_d.entry_number = entry_w;
        left_d             = left_dec;
        if (left_dec == 8'd0) begin
          out_d.key_done = 1'b1;
          phase_d        = PH_VALLEN;
        end
      end
      PH_VALLEN: begin
        out_d.byte_kind    = mtp_pkg::KIND_FRAMING;
        out_d.entry_number = entry_w;
        if (q_entry_i.cls.too_long) begin
          status_d = mtp_pkg::ST_VALLONG;
          phase_d  = PH_HALT;
        end else if (overrun) begin
          status_d = mtp_pkg::ST_VALOVER;
          phase_d  = PH_HALT;
        end else begin
          left_d = b;
          if (q_entry_i.cls.is_zero) begin
            out_d.value_done = 1'b1;
            entry_d          = entry_w + 8'd1;
            keys_d           = keys_dec;
            if (keys_dec == 8'd0) begin
              status_d = mtp_pkg::ST_DONE;
              phase_d  = PH_HALT;
            end else begin
              phase_d = PH_KEYLEN;
            end
          end else begin
            phase_d = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        out_d.byte_kind    = mtp_pkg::KIND_VALUE;
        out_d.entry_number = entry_w;
        left_d             = left_dec;
        if (left_dec == 8'd0) begin
          out_d.value_done = 1'b1;
          entry_d          = entry_w + 8'd1;
          keys_d           = keys_dec;
          if (keys_dec == 8'd0) begin
            status_d = mtp_pkg::ST_DONE;
            phase_d  = PH_HALT;
          end else begin
            phase_d = PH_KEYLEN;
          end
        end
      end
      default: begin
      end
    endcase

    if (out_d.byte_kind != mtp_pkg::KIND_IGNORED) begin
      pos_d = pos_w + 32'd1;
    end
    out_d.parse_status = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIG0;
      blen_q      <= '0;
      pos_q       <= '0;
      keys_q      <= '0;
      left_q      <= '0;
      entry_q     <= '0;
      status_q    <= mtp_pkg::ST_PARSING;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        blen_q <= cfg_wdata_i;
      end
      if (q_pop_o) begin
        phase_q  <= phase_d;
        pos_q    <= pos_d;
        keys_q   <= keys_d;
        left_q   <= left_d;
        entry_q  <= entry_d;
        status_q <= status_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

/* src/metadata_table_parser_core.sv */
// ----------------------------------------------------------------------------
// metadata_table_parser_core
// Byte-stream parser for the key/value metadata table at the front of a blob.
// ----------------------------------------------------------------------------
// Program blob_length over the cfg port while idle, then stream the blob one
// byte per word with first_byte set on byte 0. Every input word yields one
// output word carrying the byte, its kind, entry number, end-of-key and
// end-of-value marks and the parse status. The block takes one byte per clock
// cycle while neither side stalls; each byte passes through the two-entry queue
// between the classifying front and the parser, and through the output register
// that the parser writes. The input side stalls only while the queue is full.
module metadata_table_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mtp_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mtp_pkg::out_word_t out_data_o
);

  logic                  q_full;
  logic                  q_empty;
  logic                  q_push;
  logic                  q_pop;
  mtp_pkg::queue_entry_t q_wr_entry;
  mtp_pkg::queue_entry_t q_rd_entry;

  mtp_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_wr_entry)
  );

  mtp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_rd_entry)
  );

  mtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_rd_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for metadata_table_parser_core: streams well-formed,
// broken and noisy blobs under several blob_length settings and idle patterns,
// predicts every output word and compares it field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import mtp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  typedef enum logic [2:0] {
    SEEK_SIG0, SEEK_SIG1, READ_COUNT, READ_KEY_LEN,
    READ_KEY, READ_VAL_LEN, READ_VALUE, HALTED
  } parse_phase_e;

  class table_scoreboard;
    logic [31:0]  blob_len;
    parse_phase_e phase;
    logic [31:0]  position;
    logic [7:0]   keys_left;
    logic [7:0]   field_left;
    logic [7:0]   entry_idx;
    logic [2:0]   status;
    out_word_t    pending_tags[$];
    int           mismatches;
    int           checked;
    int           status_seen[8];

    function new();
      blob_len   = '0;
      mismatches = 0;
      checked    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      restart();
    endfunction

    function void restart();
      phase      = SEEK_SIG0;
      position   = '0;
      keys_left  = '0;
      field_left = '0;
      entry_idx  = '0;
      status     = ST_PARSING;
    endfunction

    function void set_blob_length(logic [31:0] v);
      blob_len = v;
    endfunction

    function int pending();
      return pending_tags.size();
    endfunction

    function void halt(logic [2:0] s);
      status = s;
      phase  = HALTED;
    endfunction

    function void close_entry();
      entry_idx = entry_idx + 8'd1;
      keys_left = keys_left - 8'd1;
      if (keys_left == 8'd0) halt(ST_DONE);
      else phase = READ_KEY_LEN;
    endfunction

    // length limit first, then field end plus footer against blob length
    function bit length_fits(logic [7:0] len, logic [2:0] too_long, logic [2:0] overrun);
      logic [63:0] field_end;
      field_end = {32'd0, position} + 64'd1 + {56'd0, len} + 64'(FOOTER_BYTES);
      if (len > MAX_FIELD_LENGTH) begin
        halt(too_long);
        return 1'b0;
      end
      if (field_end > {32'd0, blob_len}) begin
        halt(overrun);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(in_word_t w);
      out_word_t  e;
      logic [7:0] b;
      b = w.data_byte;
      e = '0;
      e.byte_out  = b;
      e.byte_kind = KIND_IGNORED;
      if (w.first_byte) restart();
      case (phase)
        SEEK_SIG0: begin
          if (blob_len <= FOOTER_BYTES || b != SIG_BYTE0) halt(ST_NOTABLE);
          else begin
            e.byte_kind = KIND_FRAMING;
            phase = SEEK_SIG1;
          end
        end
        SEEK_SIG1: begin
          if (b != SIG_BYTE1) halt(ST_NOTABLE);
          else begin
            e.byte_kind = KIND_FRAMING;
            phase = READ_COUNT;
          end
        end
        READ_COUNT: begin
          e.byte_kind = KIND_FRAMING;
          keys_left = b;
          entry_idx = '0;
          if (b == 8'd0) halt(ST_DONE);
          else phase = READ_KEY_LEN;
        end
        READ_KEY_LEN: begin
          e.byte_kind = KIND_FRAMING;
          e.entry_number = entry_idx;
          if (length_fits(b, ST_KEYLONG, ST_KEYOVER)) begin
            field_left = b;
            if (b == 8'd0) begin
              e.key_done = 1'b1;
              phase = READ_VAL_LEN;
            end else phase = READ_KEY;
          end
        end
        READ_KEY: begin
          e.byte_kind = KIND_KEY;
          e.entry_number = entry_idx;
          field_left = field_left - 8'd1;
          if (field_left == 8'd0) begin
            e.key_done = 1'b1;
            phase = READ_VAL_LEN;
          end
        end
        READ_VAL_LEN: begin
          e.byte_kind = KIND_FRAMING;
          e.entry_number = entry_idx;
          if (length_fits(b, ST_VALLONG, ST_VALOVER)) begin
            field_left = b;
            if (b == 8'd0) begin
              e.value_done = 1'b1;
              close_entry();
            end else phase = READ_VALUE;
          end
        end
        READ_VALUE: begin
          e.byte_kind = KIND_VALUE;
          e.entry_number = entry_idx;
          field_left = field_left - 8'd1;
          if (field_left == 8'd0) begin
            e.value_done = 1'b1;
            close_entry();
          end
        end
        default: ;
      endcase
      if (e.byte_kind != KIND_IGNORED) position = position + 32'd1;
      e.parse_status = status;
      pending_tags.push_back(e);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_tags(out_word_t got);
      out_word_t want;
      if (pending_tags.size() == 0) begin
        $error("output word %h with nothing pending", got);
        mismatches++;
        return;
      end
      want = pending_tags.pop_front();
      checked++;
      status_seen[got.parse_status]++;
      compare_field("byte_out", want.byte_out, got.byte_out);
      compare_field("byte_kind", want.byte_kind, got.byte_kind);
      compare_field("entry_number", want.entry_number, got.entry_number);
      compare_field("key_done", want.key_done, got.key_done);
      compare_field("value_done", want.value_done, got.value_done);
      compare_field("parse_status", want.parse_status, got.parse_status);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_word_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_word_t   out_data_o;

  table_scoreboard book;
  in_word_t        blob_q[$];
  int              send_idle_pct;
  int              recv_stall_pct;
  int              quiet_cycles;
  int              words_sent;
  int              blobs_sent;
  int              settings_used;

  metadata_table_parser_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiving side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) book.check_tags(out_data_o);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function void push_byte(logic [7:0] b, logic fb);
    in_word_t w;
    w.data_byte  = b;
    w.first_byte = fb;
    blob_q.push_back(w);
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 8'($urandom_range(255, MAX_FIELD_LENGTH + 1));
    if (r < 4) return 8'(MAX_FIELD_LENGTH);
    if (r < 5) return 8'($urandom_range(MAX_FIELD_LENGTH, 200));
    return 8'($urandom_range(6));
  endfunction

  function automatic logic [31:0] pick_setting(int k, int mode);
    case (k)
      0:       return (mode == 0) ? 32'd0 : (mode == 1) ? 32'(FOOTER_BYTES)
                                                        : 32'($urandom_range(FOOTER_BYTES));
      1:       return 32'(FOOTER_BYTES + 1);
      2:       return 32'($urandom_range(60, 18));
      3:       return 32'($urandom_range(600, 61));
      4:       return 32'hFFFF_FFFF;
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    book.note_byte(w);
    words_sent++;
  endtask

  task automatic send_blob();
    foreach (blob_q[i]) send_word(blob_q[i]);
    blob_q.delete();
    blobs_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_blob_length(input logic [31:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    book.set_blob_length(v);
    settings_used++;
  endtask

  // mostly well-formed tables with random content, some noise and broken ones
  task automatic make_blob();
    int         shape;
    int         count;
    int         cut;
    logic [7:0] flen;
    shape = $urandom_range(99);
    if (shape < 5) begin
      repeat ($urandom_range(6, 1)) push_byte(8'($urandom), 1'($urandom));
      return;
    end
    if (shape < 9) begin
      push_byte(8'($urandom), 1'b1);
      push_byte(8'($urandom), 1'b0);
      return;
    end
    push_byte(SIG_BYTE0, 1'b1);
    if (shape < 13) begin
      push_byte(8'($urandom), 1'b0);
      push_byte(8'($urandom), 1'b0);
      return;
    end
    push_byte(SIG_BYTE1, 1'b0);
    shape = $urandom_range(99);
    if (shape < 5) count = 0;
    else if (shape < 8) count = $urandom_range(255);
    else count = $urandom_range(4, 1);
    push_byte(8'(count), 1'b0);
    for (int e = 0; e < count && e < 12; e++) begin
      flen = pick_length();
      push_byte(flen, 1'b0);
      if (flen > MAX_FIELD_LENGTH) break;
      repeat (flen) push_byte(8'($urandom), 1'b0);
      flen = pick_length();
      push_byte(flen, 1'b0);
      if (flen > MAX_FIELD_LENGTH) break;
      repeat (flen) push_byte(8'($urandom), 1'b0);
    end
    repeat ($urandom_range(3)) push_byte(8'($urandom), 1'b0);
    if ($urandom_range(99) < 8) begin
      cut = $urandom_range(blob_q.size(), 1);
      while (blob_q.size() > cut) void'(blob_q.pop_back());
    end
  endtask

  initial begin
    int budget;
    int phase_bytes;
    book           = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    words_sent     = 0;
    blobs_sent     = 0;
    settings_used  = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no restart mark after reset, blob length still zero, then halted
    push_byte(SIG_BYTE0, 1'b0);
    push_byte(SIG_BYTE1, 1'b0);
    send_blob();

    write_blob_length(32'hFFFF_FFFF);
    // two entries: short key and value, then empty key and empty value
    push_byte(SIG_BYTE0, 1'b1);
    push_byte(SIG_BYTE1, 1'b0);
    push_byte(8'd2, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'd2, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd0, 1'b0);
    send_blob();
    // bad second and first signature bytes
    push_byte(SIG_BYTE0, 1'b1);
    push_byte(8'h58, 1'b0);
    send_blob();
    push_byte(8'hB2, 1'b1);
    send_blob();
    // zero entry count
    push_byte(SIG_BYTE0, 1'b1);
    push_byte(SIG_BYTE1, 1'b0);
    push_byte(8'd0, 1'b0);
    send_blob();
    // value length over the limit
    push_byte(SIG_BYTE0, 1'b1);
    push_byte(SIG_BYTE1, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'hFF, 1'b0);
    send_blob();

    // key runs into the footer
    write_blob_length(32'd20);
    push_byte(SIG_BYTE0, 1'b1);
    push_byte(SIG_BYTE1, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(8'd1, 1'b0);
    send_blob();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 9;  recv_stall_pct = 81; end
        1: begin send_idle_pct = 81; recv_stall_pct = 9;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int k = 0; k < 6; k++) begin
        write_blob_length(pick_setting(k, mode));
        budget      = (k == 0) ? 20 : 90;
        phase_bytes = 0;
        while (phase_bytes < budget) begin
          make_blob();
          // last blob of a phase is cut to the remaining byte budget
          while (phase_bytes + blob_q.size() > budget) void'(blob_q.pop_back());
          phase_bytes += blob_q.size();
          send_blob();
        end
      end
    end

    drain();
    $display("run covered %0d bytes in %0d blobs over %0d blob_length settings",
             words_sent, blobs_sent, settings_used);
    $display("words by status: parsing %0d done %0d no-table %0d key-long %0d key-over %0d %s",
             book.status_seen[ST_PARSING], book.status_seen[ST_DONE],
             book.status_seen[ST_NOTABLE], book.status_seen[ST_KEYLONG],
             book.status_seen[ST_KEYOVER],
             $sformatf("value-long %0d value-over %0d",
                       book.status_seen[ST_VALLONG], book.status_seen[ST_VALOVER]));
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
